FILE: hw/rtl/inversion_counter_core_defines.svh
// Assertion macros shared by the inversion counter RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef INVERSION_COUNTER_CORE_DEFINES_SVH
`define INVERSION_COUNTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define IC_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("inversion counter check failed");
// Checked at every edge, reset included.
`define IC_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) (expr)) \
        else $error("inversion counter check failed");
`else
`define IC_ASSERT(label, expr)
`define IC_ASSERT_ALWAYS(label, expr)
`endif
`endif

FILE: hw/rtl/ic_pkg.sv
// Package for the inversion counter: field widths, limits and the token control struct.
// No dependencies.
package ic_pkg;

    localparam int unsigned MAX_ITEMS_DEF = 1024;
    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned COUNT_W       = 19;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Control part of a token travelling down the cell chain.
    typedef struct packed {
        logic valid;
        logic last;
        logic drop;
    } t_tok_ctl;

endpackage

FILE: hw/rtl/ic_cell.sv
// One cell of the inversion counter chain: holds one stored element and passes tokens on.
// Depends on ic_pkg.
module ic_cell #(
    parameter int unsigned INDEX  = 0,
    parameter int unsigned SLOT_W = 11,
    parameter int unsigned CNT_W  = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  ic_pkg::t_tok_ctl              i_ctl,
    input  logic signed [ic_pkg::VALUE_W-1:0] i_value,
    input  logic [SLOT_W-1:0]             i_slot,
    input  logic [CNT_W-1:0]              i_count,
    output ic_pkg::t_tok_ctl              o_ctl,
    output logic signed [ic_pkg::VALUE_W-1:0] o_value,
    output logic [SLOT_W-1:0]             o_slot,
    output logic [CNT_W-1:0]              o_count
);
    import ic_pkg::*;

    localparam logic [SLOT_W-1:0] IDX = SLOT_W'(INDEX);

    t_tok_ctl                   r_ctl;
    logic signed [VALUE_W-1:0]  r_value;
    logic signed [VALUE_W-1:0]  r_elem;
    logic [SLOT_W-1:0]          r_slot;
    logic [CNT_W-1:0]           r_count;
    logic                       w_hit;
    logic                       w_store;

    // The stored element belongs to the token's sequence only if it sits before the token's slot.
    assign w_hit   = i_ctl.valid && !i_ctl.drop && (IDX < i_slot) && (r_elem > i_value);
    assign w_store = i_ctl.valid && !i_ctl.drop && (i_slot == IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= i_value;
            r_slot  <= i_slot;
            r_count <= w_hit ? CNT_W'(i_count + 1'b1) : i_count;
            if (w_store) begin
                r_elem <= i_value;
            end
        end
    end

    assign o_ctl   = r_ctl;
    assign o_value = r_value;
    assign o_slot  = r_slot;
    assign o_count = r_count;

endmodule

FILE: hw/rtl/ic_accum.sv
// Running total at the tail of the chain and the result register.
// Depends on ic_pkg.
module ic_accum #(
    parameter int unsigned CNT_W = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  ic_pkg::t_tok_ctl            i_ctl,
    input  logic [CNT_W-1:0]            i_count,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [ic_pkg::COUNT_W-1:0]  o_inversion_count,
    output logic                        o_overflow
);
    import ic_pkg::*;

    localparam int unsigned SUM_W = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;

    logic [COUNT_W-1:0] r_total;
    logic               r_ovf;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_ovf;
    logic [SUM_W-1:0]   w_sum;
    logic [COUNT_W-1:0] n_total;

    // Saturating add; a dropped token carries a zero count.
    assign w_sum   = SUM_W'(r_total) + SUM_W'(i_count);
    assign n_total = (w_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : w_sum[COUNT_W-1:0];

    // A waiting result stays until it is taken; a last token arriving fills the register.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (i_en && i_ctl.valid && i_ctl.last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_en && i_ctl.valid) begin
                if (i_ctl.last) begin
                    r_total <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_total <= n_total;
                    r_ovf   <= r_ovf | i_ctl.drop;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_ctl.valid && i_ctl.last) begin
            r_out_count <= n_total;
            r_out_ovf   <= r_ovf | i_ctl.drop;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_inversion_count = r_out_count;
    assign o_overflow        = r_out_ovf;

endmodule

FILE: hw/rtl/inversion_counter_core.sv
// Inversion counter top level: a chain of MAX_ITEMS cells, a tail accumulator and a result register.
// A last item's token is registered in every cell in turn and then in the result register.
// Throughput: one item per cycle; the whole chain freezes while a finished result is stalled.
// Reset: synchronous, active low; clears the fill count, the token valid bits and the total.
// Stored elements are not cleared; each cell is written before any token of its sequence reads it.
module inversion_counter_core #(
    parameter int unsigned MAX_ITEMS = ic_pkg::MAX_ITEMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [ic_pkg::VALUE_W-1:0]  i_value,
    input  logic                               i_last,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ic_pkg::COUNT_W-1:0]         o_inversion_count,
    output logic                               o_overflow
);
    import ic_pkg::*;
    `include "inversion_counter_core_defines.svh"

    // A slot number runs from 0 to MAX_ITEMS; MAX_ITEMS itself marks a full store.
    // A per-item count never exceeds MAX_ITEMS - 1.
    localparam int unsigned SLOT_W = $clog2(MAX_ITEMS + 1);
    localparam int unsigned CNT_W  = $clog2(MAX_ITEMS);
    localparam logic [SLOT_W-1:0] SLOT_FULL = SLOT_W'(MAX_ITEMS);

    // Token bus between cells: index g feeds cell g, index g+1 is cell g's output.
    t_tok_ctl                   w_ctl   [0:MAX_ITEMS];
    logic signed [VALUE_W-1:0]  w_value [0:MAX_ITEMS];
    logic [SLOT_W-1:0]          w_slot  [0:MAX_ITEMS];
    logic [CNT_W-1:0]           w_count [0:MAX_ITEMS];

    logic [SLOT_W-1:0] r_fill;
    logic [SLOT_W-1:0] n_fill;
    logic              w_adv;
    logic              w_accept;
    logic              w_full;

    // The chain moves whenever the result register is free or is being taken this cycle.
    assign w_adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv;
    assign w_accept   = i_in_valid && w_adv;
    assign w_full     = (r_fill == SLOT_FULL);

    // Each new token carries the slot it will occupy. Cells before that slot hold earlier
    // elements of the same sequence and add one to the count when they are greater.
    // Once the store is full, the token is marked dropped: it neither compares nor settles,
    // and only sets the overflow flag at the tail.
    always_comb begin
        w_ctl[0].valid = i_in_valid;
        w_ctl[0].last  = i_last;
        w_ctl[0].drop  = w_full;
        w_value[0]     = i_value;
        w_slot[0]      = r_fill;
        w_count[0]     = '0;
    end

    always_comb begin
        n_fill = r_fill;
        if (w_accept) begin
            if (i_last) begin
                n_fill = '0;
            end else if (!w_full) begin
                n_fill = SLOT_W'(r_fill + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // The cell row. A token reaches cell k from the output register of cell k-1, so every earlier
    // token of the sequence has already settled in its own cell when a later one arrives.
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        ic_cell #(
            .INDEX  (g),
            .SLOT_W (SLOT_W),
            .CNT_W  (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_ctl   (w_ctl[g]),
            .i_value (w_value[g]),
            .i_slot  (w_slot[g]),
            .i_count (w_count[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_value (w_value[g+1]),
            .o_slot  (w_slot[g+1]),
            .o_count (w_count[g+1])
        );
    end

    // Tokens leave the chain in arrival order; the accumulator sums their counts and
    // emits the total when the sequence's last token comes out.
    ic_accum #(
        .CNT_W (CNT_W)
    ) u_accum (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_adv),
        .i_ctl             (w_ctl[MAX_ITEMS]),
        .i_count           (w_count[MAX_ITEMS]),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_inversion_count (o_inversion_count),
        .o_overflow        (o_overflow)
    );

    // The fill count never passes the store size; before the first reset edge it is unknown.
    `IC_ASSERT_ALWAYS(a_fill_range, !i_rst_n || (r_fill <= SLOT_FULL))
    // A transfer carrying the last item starts a new sequence at slot zero.
    `IC_ASSERT(a_fill_restart, (w_accept && i_last) |=> (r_fill == '0))
    // A result appears only when a last token has just left the chain.
    `IC_ASSERT(a_result_source, $rose(o_out_valid) |->
        $past(w_ctl[MAX_ITEMS].valid && w_ctl[MAX_ITEMS].last && w_adv))

endmodule
